[hw/rtl/spc_pkg.sv]
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the sphere pair collision search.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int unsigned FIELD_BITS  = 24;
  localparam int unsigned RADIUS_BITS = 23;
  localparam int unsigned REACH_BITS  = RADIUS_BITS + 1;
  localparam int unsigned INDEX_BITS  = 8;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0]  x_position;
    logic signed [FIELD_BITS-1:0]  y_position;
    logic signed [FIELD_BITS-1:0]  z_position;
    logic        [RADIUS_BITS-1:0] sphere_radius;
    logic                          last_sphere;
  } sphere_word_t;

  typedef struct packed {
    logic                  found;
    logic [INDEX_BITS-1:0] first_index;
    logic [INDEX_BITS-1:0] second_index;
    logic                  capacity_exceeded;
  } result_word_t;

  typedef struct packed {
    logic pending;
    logic hit;
  } test_status_t;

endpackage

[hw/rtl/spc_ram.sv]
// ----------------------------------------------------------------------------
// spc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spc_ram #(
  parameter int unsigned WIDTH = 95,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/spc_pair_test.sv]
// ----------------------------------------------------------------------------
// spc_pair_test
// Pipelined sphere overlap test: box prune, squares, squared-reach compare.
// ----------------------------------------------------------------------------
module spc_pair_test #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned TAG_BITS   = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                flush,
  input  logic                                in_valid,
  input  logic [TAG_BITS-1:0]                 in_tag,
  input  logic [COORD_BITS-1:0]               ax,
  input  logic [COORD_BITS-1:0]               ay,
  input  logic [COORD_BITS-1:0]               az,
  input  logic [spc_pkg::RADIUS_BITS-1:0]     ar,
  input  logic [COORD_BITS-1:0]               bx,
  input  logic [COORD_BITS-1:0]               by,
  input  logic [COORD_BITS-1:0]               bz,
  input  logic [spc_pkg::RADIUS_BITS-1:0]     br,
  output spc_pkg::test_status_t               status,
  output logic [TAG_BITS-1:0]                 hit_tag
);

  localparam int unsigned RB  = spc_pkg::REACH_BITS;
  localparam int unsigned CMW = (COORD_BITS > RB) ? COORD_BITS : RB;
  localparam int unsigned SQW = 2 * RB;
  localparam int unsigned SMW = SQW + 2;

  logic signed [COORD_BITS:0] dx_s, dy_s, dz_s;
  logic [COORD_BITS-1:0]      adx, ady, adz;
  logic [RB-1:0]              reach;

  // stage 2: absolute differences and reach
  logic                  v2;
  logic [TAG_BITS-1:0]   tag2;
  logic [COORD_BITS-1:0] dx2, dy2, dz2;
  logic [RB-1:0]         reach2;

  // stage 3: squares
  logic                  v3;
  logic [TAG_BITS-1:0]   tag3;
  logic                  prune3;
  logic [SQW-1:0]        sx3, sy3, sz3, rr3;

  logic                  prune2;
  logic [SMW-1:0]        sum3;

  always_comb begin
    dx_s  = $signed({ax[COORD_BITS-1], ax}) - $signed({bx[COORD_BITS-1], bx});
    dy_s  = $signed({ay[COORD_BITS-1], ay}) - $signed({by[COORD_BITS-1], by});
    dz_s  = $signed({az[COORD_BITS-1], az}) - $signed({bz[COORD_BITS-1], bz});
    adx   = dx_s[COORD_BITS] ? COORD_BITS'(-dx_s) : COORD_BITS'(dx_s);
    ady   = dy_s[COORD_BITS] ? COORD_BITS'(-dy_s) : COORD_BITS'(dy_s);
    adz   = dz_s[COORD_BITS] ? COORD_BITS'(-dz_s) : COORD_BITS'(dz_s);
    reach = RB'(ar) + RB'(br);
  end

  assign prune2 = (CMW'(dx2) >= CMW'(reach2)) || (CMW'(dy2) >= CMW'(reach2)) ||
                  (CMW'(dz2) >= CMW'(reach2));

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= in_valid;
      v3 <= v2;
    end
    tag2   <= in_tag;
    dx2    <= adx;
    dy2    <= ady;
    dz2    <= adz;
    reach2 <= reach;
    tag3   <= tag2;
    prune3 <= prune2;
    sx3    <= SQW'(RB'(dx2)) * SQW'(RB'(dx2));
    sy3    <= SQW'(RB'(dy2)) * SQW'(RB'(dy2));
    sz3    <= SQW'(RB'(dz2)) * SQW'(RB'(dz2));
    rr3    <= SQW'(reach2) * SQW'(reach2);
  end

  assign sum3           = SMW'(sx3) + SMW'(sy3) + SMW'(sz3);
  assign status.pending = v2 || v3;
  assign status.hit     = v3 && !prune3 && (sum3 < SMW'(rr3));
  assign hit_tag        = tag3;

endmodule

[hw/rtl/sphere_pair_collision_search.sv]
// ----------------------------------------------------------------------------
// sphere_pair_collision_search
// Loads a set of spheres into a RAM and finds the lowest-index colliding pair.
// ----------------------------------------------------------------------------
// A sphere word is taken whenever start is high and busy is low; words without
// the last mark leave busy low. The word with the last mark starts the search,
// which holds busy high and walks all pairs (i, j), i < j, in order, testing
// one pair per cycle while a row is scanned, from a single RAM read port. Each
// row first reads sphere i, then scans j from i + 1, then waits for the pair
// test to drain before row i + 1; a hit ends the search early. The result
// appears for one cycle on result with done high and must be sampled then;
// spheres beyond MAX_SPHERES are dropped and flagged.
module sphere_pair_collision_search #(
  parameter int unsigned MAX_SPHERES = 256,
  parameter int unsigned COORD_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  spc_pkg::sphere_word_t sphere,
  output logic                  done,
  output spc_pkg::result_word_t result
);

  localparam int unsigned CW = $clog2(MAX_SPHERES + 1);
  localparam int unsigned AW = $clog2(MAX_SPHERES);
  localparam int unsigned RW = spc_pkg::RADIUS_BITS;
  localparam int unsigned EW = 3 * COORD_BITS + RW;
  localparam int unsigned IW = spc_pkg::INDEX_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_ROW   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;

  logic [2:0]            state;
  logic [CW-1:0]         count;
  logic                  overflow;
  logic [CW-1:0]         i;
  logic [CW-1:0]         j;
  logic [CW-1:0]         j1;
  logic                  v1;
  logic [COORD_BITS-1:0] ax, ay, az;
  logic [RW-1:0]         ar;

  logic                  accept;
  logic                  room;
  logic                  we;
  logic [AW-1:0]         raddr;
  logic [EW-1:0]         wdata;
  logic [EW-1:0]         rdata;
  logic                  issue;

  spc_pkg::test_status_t st;
  logic [CW-1:0]         hit_tag;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign room   = (count < CW'(MAX_SPHERES));
  assign we     = accept && room;
  assign wdata  = {COORD_BITS'($unsigned(sphere.x_position)),
                   COORD_BITS'($unsigned(sphere.y_position)),
                   COORD_BITS'($unsigned(sphere.z_position)),
                   sphere.sphere_radius};
  assign raddr  = (state == S_ROW) ? i[AW-1:0] : j[AW-1:0];
  assign issue  = (state == S_SCAN) && !st.hit && (j < count);

  spc_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SPHERES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(count[AW-1:0]),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  spc_pair_test #(
    .COORD_BITS(COORD_BITS),
    .TAG_BITS  (CW)
  ) u_test (
    .clk     (clk),
    .rst     (rst),
    .flush   (state == S_ROW),
    .in_valid(v1),
    .in_tag  (j1),
    .ax      (ax),
    .ay      (ay),
    .az      (az),
    .ar      (ar),
    .bx      (rdata[EW-1 -: COORD_BITS]),
    .by      (rdata[EW-COORD_BITS-1 -: COORD_BITS]),
    .bz      (rdata[RW+COORD_BITS-1 -: COORD_BITS]),
    .br      (rdata[RW-1:0]),
    .status  (st),
    .hit_tag (hit_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      done     <= 1'b0;
      v1       <= 1'b0;
    end else begin
      done <= 1'b0;
      v1   <= issue;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (sphere.last_sphere) begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          if (count < CW'(2)) begin
            done     <= 1'b1;
            result   <= '{found: 1'b0, first_index: '0, second_index: '0,
                          capacity_exceeded: overflow};
            count    <= '0;
            overflow <= 1'b0;
            state    <= S_IDLE;
          end else begin
            i     <= '0;
            state <= S_ROW;
          end
        end
        S_ROW: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          ax    <= rdata[EW-1 -: COORD_BITS];
          ay    <= rdata[EW-COORD_BITS-1 -: COORD_BITS];
          az    <= rdata[RW+COORD_BITS-1 -: COORD_BITS];
          ar    <= rdata[RW-1:0];
          j     <= i + CW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (st.hit) begin
            done     <= 1'b1;
            result   <= '{found: 1'b1, first_index: IW'(i), second_index: IW'(hit_tag),
                          capacity_exceeded: overflow};
            count    <= '0;
            overflow <= 1'b0;
            state    <= S_IDLE;
          end else if (j < count) begin
            j <= j + CW'(1);
          end else if (!v1 && !st.pending) begin
            if ((i + CW'(2)) >= count) begin
              done     <= 1'b1;
              result   <= '{found: 1'b0, first_index: '0, second_index: '0,
                            capacity_exceeded: overflow};
              count    <= '0;
              overflow <= 1'b0;
              state    <= S_IDLE;
            end else begin
              i     <= i + CW'(1);
              state <= S_ROW;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    j1 <= j;
  end

endmodule

[hw/rtl/spc_checker.sv]
// ----------------------------------------------------------------------------
// spc_checker
// Port-level checks on the sphere pair collision search, bound to the top.
// ----------------------------------------------------------------------------
module spc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input spc_pkg::sphere_word_t sphere,
  input logic                  done,
  input spc_pkg::result_word_t result
);

  // a result word closes a search
  a_done_ends_search: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result word without a preceding search");

  // no pair means zero indices
  a_miss_zero_index: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.first_index == '0) && (result.second_index == '0))
    else $error("miss result with nonzero index");

  // plain load word keeps the block ready
  a_load_stays_ready: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !sphere.last_sphere) |=> !busy && !done)
    else $error("load word started a search");

  // last word starts the search
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && sphere.last_sphere) |=> busy && !done)
    else $error("last word did not start a search");

endmodule

bind sphere_pair_collision_search spc_checker u_spc_checker (.*);
